// ===== design/rv32i_instruction_lowering_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// RV32I lowering decoder assertion macros
// Shared concurrent assertion shorthands for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_LOWERING_DECODER_CORE_MACROS_SVH
`define RV32I_INSTRUCTION_LOWERING_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVILD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RVILD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rvild_pkg.sv =====
// ----------------------------------------------------------------------------
// RV32I lowering decoder package
// Opcode constants, operation codes and the decoded operation record.
// ----------------------------------------------------------------------------
package rvild_pkg;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD    = 3'd0;
    localparam logic [2:0] F3_SLL    = 3'd1;
    localparam logic [2:0] F3_SR     = 3'd5;
    localparam logic [2:0] F3_BR_RA  = 3'd2;
    localparam logic [2:0] F3_BR_RB  = 3'd3;

    typedef enum logic [3:0] {
        KIND_CONST  = 4'd0,
        KIND_ALUR   = 4'd1,
        KIND_ALUI   = 4'd2,
        KIND_SHIFTI = 4'd3,
        KIND_LOAD   = 4'd4,
        KIND_STORE  = 4'd5,
        KIND_BRANCH = 4'd6,
        KIND_JAL    = 4'd7,
        KIND_JALR   = 4'd8
    } kind_t;

    typedef enum logic [3:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_XOR  = 4'd2,
        ALU_OR   = 4'd3,
        ALU_AND  = 4'd4,
        ALU_SHL  = 4'd5,
        ALU_SHR  = 4'd6,
        ALU_SAR  = 4'd7,
        ALU_SLT  = 4'd8,
        ALU_SLTU = 4'd9
    } alu_t;

    typedef enum logic [2:0] {
        COND_EQ  = 3'd0,
        COND_NE  = 3'd1,
        COND_LT  = 3'd2,
        COND_GE  = 3'd3,
        COND_LTU = 3'd4,
        COND_GEU = 3'd5
    } cond_t;

    typedef struct packed {
        logic        accepted;
        kind_t       op_kind;
        alu_t        alu_op;
        cond_t       branch_cond;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] resolved_imm;
        logic [31:0] link_value;
        logic [1:0]  mem_size_log;
        logic        mem_signed;
        logic        pc_redirect;
    } decode_t;

endpackage

// ===== design/rvild_decode.sv =====
// ----------------------------------------------------------------------------
// RV32I lowering decoder: decode logic
// Combinational decode of one registered instruction into a decode_t record.
// ----------------------------------------------------------------------------
module rvild_decode (
    input  logic [31:0]        instruction,
    input  logic [31:0]        fetch_address,
    input  logic [2:0]         instr_length,
    output rvild_pkg::decode_t dec
);
    import rvild_pkg::*;

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] target_offset;
    logic [31:0] target_sum;
    logic [31:0] link_sum;
    decode_t     raw;

    // The shared base field decode has the same alu mapping for OP and OP-IMM.
    function automatic alu_t alu_of_f3(input logic [2:0] code);
        alu_t res;
        case (code)
            3'd0:    res = ALU_ADD;
            3'd1:    res = ALU_SHL;
            3'd2:    res = ALU_SLT;
            3'd3:    res = ALU_SLTU;
            3'd4:    res = ALU_XOR;
            3'd5:    res = ALU_SHR;
            3'd6:    res = ALU_OR;
            default: res = ALU_AND;
        endcase
        return res;
    endfunction

    function automatic cond_t cond_of_f3(input logic [2:0] code);
        cond_t res;
        case (code)
            3'd0:    res = COND_EQ;
            3'd1:    res = COND_NE;
            3'd4:    res = COND_LT;
            3'd5:    res = COND_GE;
            3'd6:    res = COND_LTU;
            3'd7:    res = COND_GEU;
            default: res = COND_EQ;
        endcase
        return res;
    endfunction

    assign opcode = instruction[6:0];
    assign rd     = instruction[11:7];
    assign f3     = instruction[14:12];
    assign rs1    = instruction[19:15];
    assign rs2    = instruction[24:20];
    assign f7     = instruction[31:25];

    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
    assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
    assign imm_u = {instruction[31:12], 12'b0};

    // One adder serves the AUIPC sum and the branch and JAL targets.
    always_comb
    begin
        case (opcode)
            OPC_AUIPC:  target_offset = imm_u;
            OPC_BRANCH: target_offset = imm_b;
            default:    target_offset = imm_j;
        endcase
    end

    assign target_sum = fetch_address + target_offset;
    assign link_sum   = fetch_address + {29'b0, instr_length};

    always_comb
    begin
        raw          = '0;
        raw.accepted = 1'b1;
        case (opcode)
            OPC_LUI:
            begin
                raw.op_kind      = KIND_CONST;
                raw.dest_reg     = rd;
                raw.resolved_imm = imm_u;
            end
            OPC_AUIPC:
            begin
                raw.op_kind      = KIND_CONST;
                raw.dest_reg     = rd;
                raw.resolved_imm = target_sum;
            end
            OPC_OP_IMM:
            begin
                raw.dest_reg = rd;
                raw.src1_reg = rs1;
                if (f3 == F3_SLL || f3 == F3_SR)
                begin
                    raw.op_kind      = KIND_SHIFTI;
                    raw.resolved_imm = {27'b0, rs2};
                    if (f7 == F7_BASE)
                        raw.alu_op = (f3 == F3_SLL) ? ALU_SHL : ALU_SHR;
                    else if (f7 == F7_ALT && f3 == F3_SR)
                        raw.alu_op = ALU_SAR;
                    else
                        raw.accepted = 1'b0;
                end
                else
                begin
                    raw.op_kind      = KIND_ALUI;
                    raw.alu_op       = alu_of_f3(f3);
                    raw.resolved_imm = imm_i;
                end
            end
            OPC_OP:
            begin
                raw.op_kind  = KIND_ALUR;
                raw.dest_reg = rd;
                raw.src1_reg = rs1;
                raw.src2_reg = rs2;
                if (f7 == F7_BASE)
                    raw.alu_op = alu_of_f3(f3);
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    raw.alu_op = ALU_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    raw.alu_op = ALU_SAR;
                else
                    raw.accepted = 1'b0;
            end
            OPC_LOAD:
            begin
                raw.op_kind      = KIND_LOAD;
                raw.dest_reg     = rd;
                raw.src1_reg     = rs1;
                raw.resolved_imm = imm_i;
                raw.mem_size_log = f3[1:0];
                raw.mem_signed   = ~f3[2];
            end
            OPC_STORE:
            begin
                raw.op_kind      = KIND_STORE;
                raw.src1_reg     = rs1;
                raw.src2_reg     = rs2;
                raw.resolved_imm = imm_s;
                raw.mem_size_log = f3[1:0];
            end
            OPC_BRANCH:
            begin
                raw.op_kind      = KIND_BRANCH;
                raw.branch_cond  = cond_of_f3(f3);
                raw.src1_reg     = rs1;
                raw.src2_reg     = rs2;
                raw.resolved_imm = target_sum;
                if (f3 == F3_BR_RA || f3 == F3_BR_RB)
                    raw.accepted = 1'b0;
            end
            OPC_JAL:
            begin
                raw.op_kind      = KIND_JAL;
                raw.dest_reg     = rd;
                raw.resolved_imm = target_sum;
                raw.link_value   = link_sum;
                raw.pc_redirect  = 1'b1;
            end
            OPC_JALR:
            begin
                raw.op_kind      = KIND_JALR;
                raw.dest_reg     = rd;
                raw.src1_reg     = rs1;
                raw.resolved_imm = imm_i;
                raw.link_value   = link_sum;
                raw.pc_redirect  = 1'b1;
            end
            default:
            begin
                raw.accepted = 1'b0;
            end
        endcase
    end

    // A rejected encoding shows every field as zero.
    assign dec = raw.accepted ? raw : '0;

endmodule

// ===== design/rv32i_instruction_lowering_decoder_core.sv =====
// ----------------------------------------------------------------------------
// RV32I lowering decoder core: one decode pass between two registers.
// Throughput one instruction per cycle unless result_ready stalls the output.
// Reset (rst_n low) empties both pipeline stages; payload registers are not reset.
// ----------------------------------------------------------------------------
module rv32i_instruction_lowering_decoder_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        instr_valid,
    output logic        instr_ready,
    input  logic [31:0] instruction,
    input  logic [31:0] fetch_address,
    input  logic [2:0]  instr_length,

    output logic        result_valid,
    input  logic        result_ready,
    output logic        accepted,
    output logic [3:0]  op_kind,
    output logic [3:0]  alu_op,
    output logic [2:0]  branch_cond,
    output logic [4:0]  dest_reg,
    output logic [4:0]  src1_reg,
    output logic [4:0]  src2_reg,
    output logic [31:0] resolved_imm,
    output logic [31:0] link_value,
    output logic [1:0]  mem_size_log,
    output logic        mem_signed,
    output logic        pc_redirect
);
    import rvild_pkg::*;

    // The input stage holds the raw instruction beat. The decode logic works
    // on that register and its record lands in the result register. Both
    // stages move together like a two-deep pipeline, so a new beat can enter
    // each cycle while the result side is draining.
    logic        stage_valid_reg;
    logic        stage_valid_next;
    logic [31:0] instr_reg;
    logic [31:0] addr_reg;
    logic [2:0]  len_reg;

    logic        result_valid_reg;
    logic        result_valid_next;
    decode_t     result_reg;
    decode_t     decoded;

    logic        result_load;
    logic        stage_load;

    // The result register takes a new record whenever it is empty or its
    // current beat leaves in this cycle.
    assign result_load = !result_valid_reg || result_ready;

    // The input stage can take a beat when it is empty or when its content
    // moves on into the result register.
    assign instr_ready = !stage_valid_reg || result_load;
    assign stage_load  = instr_valid && instr_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (instr_ready)
            stage_valid_next = instr_valid;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_load)
            result_valid_next = stage_valid_reg;
    end

    rvild_decode u_decode (
        .instruction   (instr_reg),
        .fetch_address (addr_reg),
        .instr_length  (len_reg),
        .dec           (decoded)
    );

    // Control state: the two valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers need no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            instr_reg <= instruction;
            addr_reg  <= fetch_address;
            len_reg   <= instr_length;
        end
        if (result_load && stage_valid_reg)
            result_reg <= decoded;
    end

    assign result_valid = result_valid_reg;
    assign accepted     = result_reg.accepted;
    assign op_kind      = result_reg.op_kind;
    assign alu_op       = result_reg.alu_op;
    assign branch_cond  = result_reg.branch_cond;
    assign dest_reg     = result_reg.dest_reg;
    assign src1_reg     = result_reg.src1_reg;
    assign src2_reg     = result_reg.src2_reg;
    assign resolved_imm = result_reg.resolved_imm;
    assign link_value   = result_reg.link_value;
    assign mem_size_log = result_reg.mem_size_log;
    assign mem_signed   = result_reg.mem_signed;
    assign pc_redirect  = result_reg.pc_redirect;

endmodule

// ===== design/rvild_checker.sv =====
// ----------------------------------------------------------------------------
// RV32I lowering decoder checker
// Port-level assertions on result beats, bound to the decoder core.
// ----------------------------------------------------------------------------
`include "rv32i_instruction_lowering_decoder_core_macros.svh"

module rvild_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic        accepted,
    input logic [3:0]  op_kind,
    input logic [3:0]  alu_op,
    input logic [2:0]  branch_cond,
    input logic [4:0]  dest_reg,
    input logic [4:0]  src1_reg,
    input logic [4:0]  src2_reg,
    input logic [31:0] resolved_imm,
    input logic [31:0] link_value,
    input logic [1:0]  mem_size_log,
    input logic        mem_signed,
    input logic        pc_redirect
);
    import rvild_pkg::*;

    // A rejected beat carries nothing but zeros.
    `RVILD_ASSERT_NOW(a_reject_zero, clk, rst_n, result_valid && !accepted, op_kind == KIND_CONST && alu_op == ALU_ADD && branch_cond == COND_EQ && dest_reg == '0 && src1_reg == '0 && src2_reg == '0 && resolved_imm == '0 && link_value == '0 && mem_size_log == '0 && !mem_signed && !pc_redirect, "rejected result has nonzero fields")

    // Only jumps end the block and carry a link value.
    `RVILD_ASSERT_NOW(a_ends_jump, clk, rst_n, result_valid && (pc_redirect || link_value != '0), accepted && (op_kind == KIND_JAL || op_kind == KIND_JALR), "link or block end on a non-jump")

    // Sign extension only applies to loads.
    `RVILD_ASSERT_NOW(a_signed_load, clk, rst_n, result_valid && mem_signed, op_kind == KIND_LOAD, "mem_signed set outside a load")

    // A stalled result beat stays put.
    `RVILD_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(resolved_imm) && $stable(op_kind), "stalled result beat changed")

endmodule

bind rv32i_instruction_lowering_decoder_core rvild_checker u_rvild_checker (.*);
